>>> rtl/core/ptps_pkg.sv
// Shared types and constants for the pulsed tone pattern sequencer.
// No dependencies; used by ptps_in_stage, ptps_seq and the core top level.
package ptps_pkg;

  localparam logic [7:0] INFINITE_COUNT_DEF = 8'd255;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_FORCE = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] pause_time;
    logic [7:0]  tone_count;
    logic [7:0]  repeat_count;
    logic        force_level;
  } item_t;

  typedef struct packed {
    logic buzzer_level;
    logic busy_res;
  } res_t;

endpackage

>>> rtl/core/ptps_if.sv
// Valid/ready channel interfaces for the item and result streams.
// Depends on nothing; the fields mirror ptps_pkg::item_t and ptps_pkg::res_t.
interface ptps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic [15:0] on_time;
  logic [15:0] off_time;
  logic [15:0] pause_time;
  logic [7:0]  tone_count;
  logic [7:0]  repeat_count;
  logic        force_level;

  modport source (output valid, action, now_ms, on_time, off_time, pause_time,
                  tone_count, repeat_count, force_level, input ready);
  modport sink   (input valid, action, now_ms, on_time, off_time, pause_time,
                  tone_count, repeat_count, force_level, output ready);
endinterface

interface ptps_out_if;
  logic valid;
  logic ready;
  logic buzzer_level;
  logic busy_res;

  modport source (output valid, buzzer_level, busy_res, input ready);
  modport sink   (input valid, buzzer_level, busy_res, output ready);
endinterface

>>> rtl/core/ptps_in_stage.sv
// Input register stage: captures one item per transfer on the input channel.
// Depends on ptps_pkg and ptps_in_if.
module ptps_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  ptps_in_if.sink         in_ch,
  input  logic            take,
  output logic            item_valid,
  output ptps_pkg::item_t item
);

  logic            valid_r, valid_nxt;
  ptps_pkg::item_t item_r;
  logic            load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{action:       in_ch.action,
                  now_ms:       in_ch.now_ms,
                  on_time:      in_ch.on_time,
                  off_time:     in_ch.off_time,
                  pause_time:   in_ch.pause_time,
                  tone_count:   in_ch.tone_count,
                  repeat_count: in_ch.repeat_count,
                  force_level:  in_ch.force_level};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/core/ptps_seq.sv
// Sequencer state and single-pass next-state logic for tick, start and force.
// Depends on ptps_pkg.
module ptps_seq #(
  parameter logic [7:0] INFINITE_COUNT = ptps_pkg::INFINITE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  ptps_pkg::item_t item,
  output ptps_pkg::res_t  res
);

  logic        level_r, level_nxt;
  logic [8:0]  step_r, step_nxt;
  logic [8:0]  total_r, total_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic [31:0] last_r, last_nxt;
  logic [15:0] on_r, on_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] pause_r, pause_nxt;

  logic [15:0] delay;
  logic [31:0] elapsed;
  logic        go;
  logic [8:0]  step_inc;
  logic        wrap;
  logic [7:0]  rep_dec;
  logic [8:0]  step_adv;
  logic [8:0]  total_m1;

  assign total_m1 = total_r - 9'd1;
  assign elapsed  = item.now_ms - last_r;

  always_comb begin
    if (step_r == 9'd0) begin
      delay = on_r;
    end else if (total_r != 9'd0 && step_r < total_m1) begin
      delay = step_r[0] ? off_r : on_r;
    end else begin
      delay = pause_r;
    end
  end

  assign go       = (rep_r != 8'd0) && (elapsed >= {16'd0, delay});
  assign step_inc = step_r + 9'd1;
  assign wrap     = (step_inc == total_r);
  assign rep_dec  = (wrap && rep_r < INFINITE_COUNT) ? rep_r - 8'd1 : rep_r;
  assign step_adv = wrap ? 9'd0 : step_inc;

  always_comb begin
    level_nxt = level_r;
    step_nxt  = step_r;
    total_nxt = total_r;
    rep_nxt   = rep_r;
    last_nxt  = last_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    pause_nxt = pause_r;
    if (fire) begin
      case (item.action)
        ptps_pkg::ACT_TICK: begin
          if (go) begin
            step_nxt = step_adv;
            rep_nxt  = rep_dec;
            last_nxt = item.now_ms;
            if (rep_dec != 8'd0) begin
              level_nxt = !level_r;
            end
            if (rep_dec == 8'd1 && total_r != 9'd0 && step_adv == total_m1) begin
              rep_nxt  = 8'd0;
              step_nxt = 9'd0;
            end
          end
        end
        ptps_pkg::ACT_START: begin
          on_nxt    = item.on_time;
          off_nxt   = item.off_time;
          pause_nxt = item.pause_time;
          total_nxt = (item.tone_count != 8'd0) ? {item.tone_count, 1'b0} : 9'd1;
          rep_nxt   = item.repeat_count;
          step_nxt  = 9'd0;
          level_nxt = 1'b1;
          last_nxt  = item.now_ms;
        end
        ptps_pkg::ACT_FORCE: begin
          total_nxt = 9'd0;
          step_nxt  = 9'd0;
          rep_nxt   = 8'd0;
          level_nxt = item.force_level;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      step_r  <= 9'd0;
      total_r <= 9'd0;
      rep_r   <= 8'd0;
      last_r  <= 32'd0;
      on_r    <= 16'd0;
      off_r   <= 16'd0;
      pause_r <= 16'd0;
    end else begin
      level_r <= level_nxt;
      step_r  <= step_nxt;
      total_r <= total_nxt;
      rep_r   <= rep_nxt;
      last_r  <= last_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
      pause_r <= pause_nxt;
    end
  end

  assign res = '{buzzer_level: level_nxt, busy_res: (rep_nxt != 8'd0)};

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_r == 8'd0) |-> (step_r == 9'd0))
    else $error("step nonzero while idle");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_r != 8'd0) |-> (step_r < total_r))
    else $error("step beyond step total while running");

  a_force_level: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.action == ptps_pkg::ACT_FORCE) |=>
      (level_r == $past(item.force_level) && rep_r == 8'd0))
    else $error("force did not set level and stop");

  a_idle_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.action == ptps_pkg::ACT_TICK && rep_r == 8'd0) |=>
      $stable(level_r) && $stable(last_r))
    else $error("idle tick changed state");

endmodule

>>> rtl/core/pulsed_tone_pattern_sequencer_core.sv
// Top level of the pulsed tone pattern sequencer: input stage, sequencer, result register.
// Depends on ptps_pkg, ptps_if, ptps_in_stage and ptps_seq.
//
// Every item (tick, start or force) yields exactly one result: the buzzer level and
// busy flag after that item. An item goes from input transfer to result through the
// input register, then the result register; one item is taken every cycle while the
// result register drains or is empty. The only loop is the state update in ptps_seq.
// The input register takes a new item when it is empty or when its item moves on.
module pulsed_tone_pattern_sequencer_core #(
  parameter logic [7:0] INFINITE_COUNT = ptps_pkg::INFINITE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ptps_in_if.sink   in_ch,
  ptps_out_if.source out_ch
);

  logic            item_valid;
  ptps_pkg::item_t item;
  ptps_pkg::res_t  res;
  logic            take;

  logic            out_valid_r, out_valid_nxt;
  ptps_pkg::res_t  out_res_r;

  assign take          = item_valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = take || (out_valid_r && !out_ch.ready);

  ptps_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ptps_seq #(
    .INFINITE_COUNT (INFINITE_COUNT)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .item  (item),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.buzzer_level = out_res_r.buzzer_level;
  assign out_ch.busy_res     = out_res_r.busy_res;

endmodule
